>>> src/sorted_schedule_table_defines.svh
// Assertion macros used by the checker file sst_checker.sv.
`ifndef SORTED_SCHEDULE_TABLE_DEFINES_SVH
`define SORTED_SCHEDULE_TABLE_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define SST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define SST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// Types and codes shared by the schedule table modules.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // One stored flight record.
    typedef struct packed {
        logic [15:0] id;
        logic [39:0] depart;
        logic [39:0] arrive;
        logic [63:0] origin;
        logic [63:0] dest;
        logic [7:0]  runway;
    } t_record;

    // One queued command between the front and the back.
    typedef struct packed {
        logic [1:0] opcode;
        t_record    rec;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_HOLD
    } t_state;

endpackage

>>> src/sst_front.sv
// ----------------------------------------------------------------------------
// sst_front
// Accepts input words and queues them as commands for the table engine.
// ----------------------------------------------------------------------------
module sst_front import sst_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  t_record     i_rec,
    output logic        o_cmd_valid,
    input  logic        i_cmd_take,
    output t_cmd        o_cmd
);

    // Two-entry command queue.
    t_cmd       r_q [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    logic       push, pop;

    assign o_stall     = (r_count == 2'd2);
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_count != 2'd0);
    assign pop         = i_cmd_take && o_cmd_valid;
    assign o_cmd       = r_q[r_rptr];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= '{opcode: i_opcode, rec: i_rec};
        end
    end

    // Queue pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) r_wptr <= ~r_wptr;
            if (pop)  r_rptr <= ~r_rptr;
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

>>> src/sst_back.sv
// ----------------------------------------------------------------------------
// sst_back
// Row of record cells with parallel compare, shift on insert and remove.
// ----------------------------------------------------------------------------
module sst_back import sst_pkg::*; #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    output logic        o_cmd_take,
    input  t_cmd        i_cmd,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output t_record     o_rec,
    output logic [4:0]  o_fill_count
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_state         r_state, n_state;
    t_cmd           r_cmd;
    t_record        r_cell [TABLE_DEPTH];
    logic [CW-1:0]  r_used;
    logic [TABLE_DEPTH-1:0] r_ge, r_hit;
    logic           r_valid;
    logic [1:0]     r_status;
    t_record        r_out;
    logic           take, exec;
    logic [TABLE_DEPTH-1:0] ins_mask, rem_mask;
    logic           found;
    t_record        hit_rec;

    // Sequencer: latch command, compare in cells, then update and report.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_cmd_valid) n_state = S_EXEC;
            S_EXEC: n_state = S_HOLD;
            S_HOLD: if (!r_valid || !i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        take = 1'b0;
        exec = 1'b0;
        unique case (r_state)
            S_IDLE:  take = i_cmd_valid;
            S_EXEC:  exec = 1'b0;
            S_HOLD:  exec = !r_valid || !i_stall;
            default: take = 1'b0;
        endcase
    end
    assign o_cmd_take = take;

    // First matching cell and masks that pick which cells shift.
    always_comb begin
        ins_mask  = '0;
        rem_mask  = '0;
        found     = 1'b0;
        hit_rec   = '0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (r_hit[k] && !found) begin
                hit_rec = r_cell[k];
            end
            found       = found | r_hit[k];
            rem_mask[k] = found;
            ins_mask[k] = (k == 0) ? r_ge[0] : (ins_mask[k-1] | r_ge[k]);
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_valid && !i_stall) r_valid <= 1'b0;
            if (exec) begin
                r_valid <= 1'b1;
                if (r_cmd.opcode == OP_INSERT && r_used < CW'(TABLE_DEPTH)) begin
                    r_used <= r_used + 1'b1;
                end else if (r_cmd.opcode == OP_REMOVE && found) begin
                    r_used <= r_used - 1'b1;
                end
            end
        end
    end

    // Command latch, per-cell compares, cell row and result word.
    always_ff @(posedge i_clk) begin
        if (take) r_cmd <= i_cmd;
        if (r_state == S_EXEC) begin
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                r_ge[k]  <= (CW'(k) < r_used) && (r_cell[k].depart >= r_cmd.rec.depart);
                r_hit[k] <= (CW'(k) < r_used) && (r_cell[k].id == r_cmd.rec.id);
            end
        end
        if (exec) begin
            r_out    <= '0;
            r_status <= ST_DONE;
            case (r_cmd.opcode)
                OP_INSERT: begin
                    if (r_used >= CW'(TABLE_DEPTH)) begin
                        r_status <= ST_FULL;
                    end else begin
                        for (int k = 0; k < TABLE_DEPTH; k++) begin
                            if (CW'(k) == r_used && !(|r_ge)) begin
                                r_cell[k] <= r_cmd.rec;
                            end else if (ins_mask[k]) begin
                                if (k == 0 || r_ge[k] && !ins_mask[(k == 0) ? 0 : k-1]) begin
                                    r_cell[k] <= r_cmd.rec;
                                end else begin
                                    r_cell[k] <= r_cell[(k == 0) ? 0 : k-1];
                                end
                            end
                        end
                    end
                end
                OP_REMOVE, OP_LOOKUP: begin
                    if (!found) begin
                        r_status <= ST_NOT_FOUND;
                    end else begin
                        r_out <= hit_rec;
                        if (r_cmd.opcode == OP_REMOVE) begin
                            for (int k = 0; k < TABLE_DEPTH - 1; k++) begin
                                if (rem_mask[k]) r_cell[k] <= r_cell[k+1];
                            end
                        end
                    end
                end
                default: r_status <= ST_DONE;
            endcase
        end
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_rec        = r_out;
    assign o_fill_count = 5'(r_used);

endmodule

>>> src/sorted_schedule_table.sv
// ----------------------------------------------------------------------------
// sorted_schedule_table
// Bounded flight table kept sorted by departure time: insert, remove, lookup.
// ----------------------------------------------------------------------------
// Channel | Handshake          | Word
// input   | i_valid / o_stall  | opcode, record fields
// output  | o_valid / i_stall  | status, record fields, fill count
//
// Each word passes three steps in the table engine: latch, per-cell compare,
// then shift and report. A two-word queue in front lets input arrive while
// the engine or the output is busy. Reset empties the table at once; cell
// contents are not cleared. A stalled output word holds the engine.
module sorted_schedule_table import sst_pkg::*; #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_flight_id,
    input  logic [39:0] i_depart_time,
    input  logic [39:0] i_arrive_time,
    input  logic [63:0] i_origin_code,
    input  logic [63:0] i_dest_code,
    input  logic [7:0]  i_runway,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_out_flight_id,
    output logic [39:0] o_out_depart_time,
    output logic [39:0] o_out_arrive_time,
    output logic [63:0] o_out_origin_code,
    output logic [63:0] o_out_dest_code,
    output logic [7:0]  o_out_runway,
    output logic [4:0]  o_fill_count
);

    t_record in_rec, out_rec;
    t_cmd    cmd;
    logic    cmd_valid, cmd_take;

    assign in_rec = '{id: i_flight_id, depart: i_depart_time, arrive: i_arrive_time,
                      origin: i_origin_code, dest: i_dest_code, runway: i_runway};

    sst_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_opcode,
        .i_rec(in_rec), .o_cmd_valid(cmd_valid), .i_cmd_take(cmd_take), .o_cmd(cmd)
    );

    sst_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .o_cmd_take(cmd_take),
        .i_cmd(cmd), .o_valid, .i_stall, .o_status, .o_rec(out_rec), .o_fill_count
    );

    assign o_out_flight_id   = out_rec.id;
    assign o_out_depart_time = out_rec.depart;
    assign o_out_arrive_time = out_rec.arrive;
    assign o_out_origin_code = out_rec.origin;
    assign o_out_dest_code   = out_rec.dest;
    assign o_out_runway      = out_rec.runway;

endmodule

>>> src/sst_checker.sv
// ----------------------------------------------------------------------------
// sst_checker
// Port-level checks on the schedule table.
// ----------------------------------------------------------------------------
`include "sorted_schedule_table_defines.svh"
module sst_checker import sst_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_status,
    input logic [4:0] o_fill_count,
    input logic [15:0] o_out_flight_id
);

    // A stalled output word holds.
    `SST_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, $stable(o_status))
    // Status is never the unused code.
    `SST_ASSERT_IMP(a_status, i_clk, i_rst_n, o_valid, o_status != 2'd3)
    // A full refusal reports a nonzero fill count.
    `SST_ASSERT_IMP(a_full, i_clk, i_rst_n, o_valid && o_status == ST_FULL,
        o_fill_count != 5'd0)
    // A miss carries a zero record.
    `SST_ASSERT_IMP(a_miss, i_clk, i_rst_n, o_valid && o_status == ST_NOT_FOUND,
        o_out_flight_id == 16'd0)

endmodule

bind sorted_schedule_table sst_checker u_checker (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_status, .o_fill_count, .o_out_flight_id
);

>>> tb/sorted_schedule_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_schedule_table_checker
// Watches both channels of the schedule table, keeps its own sorted copy of
// the flight table, predicts each result word and compares it field by field.
// ----------------------------------------------------------------------------
module sorted_schedule_table_checker import sst_pkg::*; #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_flight_id,
    input  logic [39:0] i_depart_time,
    input  logic [39:0] i_arrive_time,
    input  logic [63:0] i_origin_code,
    input  logic [63:0] i_dest_code,
    input  logic [7:0]  i_runway,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_status,
    input  logic [15:0] i_out_flight_id,
    input  logic [39:0] i_out_depart_time,
    input  logic [39:0] i_out_arrive_time,
    input  logic [63:0] i_out_origin_code,
    input  logic [63:0] i_out_dest_code,
    input  logic [7:0]  i_out_runway,
    input  logic [4:0]  i_fill_count,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_fill
);

    typedef struct packed {
        logic [1:0] status;
        t_record    rec;
        logic [4:0] fill;
    } t_reply;

    t_record flights[TABLE_DEPTH];
    int      flight_count;
    t_reply  expected_replies[$];

    assign o_pending = expected_replies.size();
    assign o_fill    = flight_count;

    // Apply one command to the local table and return the reply it gives.
    function automatic t_reply apply_command(logic [1:0] op, t_record rec);
        t_reply r;
        int     pos;
        r = '0;
        if (op == OP_INSERT) begin
            if (flight_count >= TABLE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                pos = flight_count;
                for (int i = flight_count - 1; i >= 0; i--) begin
                    if (flights[i].depart >= rec.depart) pos = i;
                end
                for (int i = flight_count; i > pos; i--) flights[i] = flights[i - 1];
                flights[pos] = rec;
                flight_count++;
            end
        end else if (op == OP_REMOVE || op == OP_LOOKUP) begin
            pos = -1;
            for (int i = flight_count - 1; i >= 0; i--) begin
                if (flights[i].id == rec.id) pos = i;
            end
            if (pos < 0) begin
                r.status = ST_NOT_FOUND;
            end else begin
                r.rec = flights[pos];
                if (op == OP_REMOVE) begin
                    for (int i = pos; i + 1 < flight_count; i++) flights[i] = flights[i + 1];
                    flight_count--;
                end
            end
        end
        r.fill = 5'(flight_count);
        return r;
    endfunction

    // Predict on each accepted input word, compare on each accepted result word.
    always @(posedge i_clk) begin
        t_record in_rec;
        t_reply  got;
        t_reply  want;
        if (!i_rst_n) begin
            flight_count = 0;
            expected_replies.delete();
            o_fail_count = 0;
        end else begin
            if (i_valid && !i_in_stall) begin
                in_rec = {i_flight_id, i_depart_time, i_arrive_time,
                          i_origin_code, i_dest_code, i_runway};
                expected_replies.push_back(apply_command(i_opcode, in_rec));
            end
            if (i_out_valid && !i_out_stall) begin
                got = {i_status, i_out_flight_id, i_out_depart_time, i_out_arrive_time,
                       i_out_origin_code, i_out_dest_code, i_out_runway, i_fill_count};
                if (expected_replies.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("Unexpected result word %h", got);
                end else begin
                    want = expected_replies.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("Mismatch: status %0d/%0d id %h/%h dep %h/%h arr %h/%h org %h/%h dst %h/%h rwy %h/%h fill %0d/%0d (expected/actual)",
                                     want.status, got.status, want.rec.id, got.rec.id,
                                     want.rec.depart, got.rec.depart,
                                     want.rec.arrive, got.rec.arrive,
                                     want.rec.origin, got.rec.origin,
                                     want.rec.dest, got.rec.dest,
                                     want.rec.runway, got.rec.runway,
                                     want.fill, got.fill);
                    end
                end
            end
        end
    end

endmodule

>>> tb/sorted_schedule_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_schedule_table_test
// Drives insert, remove, lookup and unused commands into the schedule table
// under random idling and long output hold-offs; the checker judges results.
// ----------------------------------------------------------------------------
module sorted_schedule_table_test;
    import sst_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_opcode = OP_NOP;
    logic [15:0] i_flight_id = '0;
    logic [39:0] i_depart_time = '0;
    logic [39:0] i_arrive_time = '0;
    logic [63:0] i_origin_code = '0;
    logic [63:0] i_dest_code = '0;
    logic [7:0]  i_runway = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [15:0] o_out_flight_id;
    logic [39:0] o_out_depart_time;
    logic [39:0] o_out_arrive_time;
    logic [63:0] o_out_origin_code;
    logic [63:0] o_out_dest_code;
    logic [7:0]  o_out_runway;
    logic [4:0]  o_fill_count;

    int fail_count;
    int pending;
    int table_fill;
    int send_idle_pct = 31;
    int recv_idle_pct = 86;
    int hold_off_cycles = 0;
    int cycle_count = 0;

    always #4 i_clk = ~i_clk;

    sorted_schedule_table #(.TABLE_DEPTH(DEPTH)) uut (.*);

    sorted_schedule_table_checker #(.TABLE_DEPTH(DEPTH)) checker_inst (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall), .i_opcode, .i_flight_id,
        .i_depart_time, .i_arrive_time, .i_origin_code, .i_dest_code, .i_runway,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_status(o_status),
        .i_out_flight_id(o_out_flight_id), .i_out_depart_time(o_out_depart_time),
        .i_out_arrive_time(o_out_arrive_time), .i_out_origin_code(o_out_origin_code),
        .i_out_dest_code(o_out_dest_code), .i_out_runway(o_out_runway),
        .i_fill_count(o_fill_count), .o_fail_count(fail_count), .o_pending(pending),
        .o_fill(table_fill)
    );

    // Receiver stall: a counted hold-off when asked, otherwise random idling.
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Offer one word and hold it until accepted, with random idle gaps first.
    // Valid stays high after acceptance so words can follow back to back.
    task automatic send_word(logic [1:0] op, logic [15:0] id, logic [39:0] dep,
                             logic [39:0] arr, logic [63:0] org, logic [63:0] dst,
                             logic [7:0] rwy);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_opcode      <= op;
        i_flight_id   <= id;
        i_depart_time <= dep;
        i_arrive_time <= arr;
        i_origin_code <= org;
        i_dest_code   <= dst;
        i_runway      <= rwy;
        do @(posedge i_clk); while (o_stall);
    endtask

    function automatic logic [39:0] hhmm(int minutes);
        int h;
        int m;
        h = (minutes / 60) % 24;
        m = minutes % 60;
        return {8'(8'h30 + h / 10), 8'(8'h30 + h % 10), 8'h3a,
                8'(8'h30 + m / 10), 8'(8'h30 + m % 10)};
    endfunction

    // Random word: mostly well-formed inserts, removes and lookups on a small
    // identifier pool so hits and duplicates are common; some raw noise.
    task automatic send_random;
        logic [1:0]  op;
        logic [15:0] id;
        logic [39:0] dep;
        int          pick;
        pick = $urandom_range(99);
        if (table_fill > 12)
            op = (pick < 30) ? OP_INSERT : (pick < 75) ? OP_REMOVE :
                 (pick < 97) ? OP_LOOKUP : OP_NOP;
        else
            op = (pick < 50) ? OP_INSERT : (pick < 75) ? OP_REMOVE :
                 (pick < 97) ? OP_LOOKUP : OP_NOP;
        id  = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(23));
        dep = ($urandom_range(9) == 0) ? {$urandom, 8'($urandom)}
                                       : hhmm($urandom_range(40) * 30);
        send_word(op, id, dep, {$urandom, 8'($urandom)}, {$urandom, $urandom},
                  {$urandom, $urandom}, 8'($urandom));
    endtask

    // Stop offering and wait until every expected result has come.
    task automatic wait_drained;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: misses on an empty table, unused opcode, all-ones fields.
        send_word(OP_LOOKUP, 16'h0001, '0, '0, '0, '0, '0);
        send_word(OP_REMOVE, 16'hffff, '0, '0, '0, '0, '0);
        send_word(OP_NOP, 16'hffff, '1, '1, '1, '1, '1);
        send_word(OP_INSERT, 16'hffff, '1, '1, '1, '1, '1);
        send_word(OP_INSERT, 16'h0000, '0, '0, '0, '0, '0);
        // Equal keys and a duplicate identifier.
        send_word(OP_INSERT, 16'h0005, hhmm(600), hhmm(660), "LISBON", "PORTO", 8'd3);
        send_word(OP_INSERT, 16'h0005, hhmm(600), hhmm(700), "MADRID", "ROME", 8'd7);
        send_word(OP_LOOKUP, 16'h0005, '0, '0, '0, '0, '0);
        send_word(OP_REMOVE, 16'h0005, '0, '0, '0, '0, '0);
        send_word(OP_LOOKUP, 16'h0005, '0, '0, '0, '0, '0);
        send_word(OP_LOOKUP, 16'hffff, '0, '0, '0, '0, '0);
        // Fill past capacity so inserts are refused.
        for (int k = 0; k < 15; k++)
            send_word(OP_INSERT, 16'(100 + k), hhmm(($urandom_range(47)) * 30),
                      '1, {$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom));
        for (int k = 0; k < 4; k++) send_random();

        // Sender pauses until every result has come.
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 86;
                recv_idle_pct = 31;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < 530; n++) begin
                if (n == 100) hold_off_cycles <= 300;
                send_random();
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> sorted_schedule_table.f
+incdir+src
src/sst_pkg.sv
src/sst_front.sv
src/sst_back.sv
src/sorted_schedule_table.sv
src/sst_checker.sv
tb/sorted_schedule_table_checker.sv
tb/sorted_schedule_table_test.sv
